// ----- sv/hbo_pkg.sv -----
// ----------------------------------------------------------------------------
// hbo_pkg
// Shared types and constants for the hash bucket occupancy histogram.
// ----------------------------------------------------------------------------
package hbo_pkg;

    localparam int WORD_W  = 64;              // one key word
    localparam int KEY_W   = 4 * WORD_W;      // full key
    localparam int MOD_W   = 17;              // bucket count / remainder width
    localparam int OCC_W   = 5;               // occupancy field
    localparam int TOTAL_W = 17;              // bucket total field
    localparam int DIGIT_W = 8;               // key bits reduced per cycle
    localparam int STEPS   = KEY_W / DIGIT_W; // reduction steps per key
    localparam int STEP_W  = $clog2(STEPS);

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_SWEEP = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    // Control from the sequencer to the bin counter bank
    typedef struct packed {
        logic clear;  // zero all bins
        logic inc;    // saturating increment of the selected bin
        logic shift;  // move bins down by one, head leaves
    } bin_ctrl_t;

endpackage

// ----- sv/hbo_mod_unit.sv -----
// ----------------------------------------------------------------------------
// hbo_mod_unit
// Iterative key reduction: key mod modulus, DIGIT_W bits per cycle.
// ----------------------------------------------------------------------------
module hbo_mod_unit
    import hbo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    input  logic [MOD_W-1:0] modulus,
    output logic             done,
    output logic [MOD_W-1:0] remainder
);

    logic [KEY_W-1:0]  key_reg,  key_next;
    logic [MOD_W-1:0]  mod_reg,  mod_next;
    logic [MOD_W-1:0]  rem_reg,  rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [MOD_W:0]    part;

    // DIGIT_W shift/compare/subtract steps; the partial remainder stays below modulus
    always_comb
    begin
        part = {1'b0, rem_reg};
        for (int j = 0; j < DIGIT_W; j++)
        begin
            part = {part[MOD_W-1:0], key_reg[KEY_W-1-j]};
            if (part >= {1'b0, mod_reg})
                part = part - {1'b0, mod_reg};
        end
    end

    always_comb
    begin
        key_next  = key_reg;
        mod_next  = mod_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            key_next  = key;
            mod_next  = modulus;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            key_next  = key_reg << DIGIT_W;
            rem_next  = part[MOD_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        mod_reg <= mod_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/hbo_tally_mem.sv -----
// ----------------------------------------------------------------------------
// hbo_tally_mem
// Single-port bucket tally memory, registered read, read-before-write.
// ----------------------------------------------------------------------------
module hbo_tally_mem
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 5
)
(
    input  logic          clk,
    input  logic [AW-1:0] addr,
    input  logic          rd_en,
    input  logic          we,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/hbo_bin_bank.sv -----
// ----------------------------------------------------------------------------
// hbo_bin_bank
// Occupancy bin counters: clear, saturating increment, shift-out at the head.
// ----------------------------------------------------------------------------
module hbo_bin_bank
    import hbo_pkg::*;
#(
    parameter int BINS = 20,
    parameter int BW   = 5
)
(
    input  logic               clk,
    input  bin_ctrl_t          ctrl,
    input  logic [BW-1:0]      bin_sel,
    output logic [TOTAL_W-1:0] head
);

    logic [TOTAL_W-1:0] bins_reg  [BINS];
    logic [TOTAL_W-1:0] bins_next [BINS];
    logic [TOTAL_W-1:0] sel_val;

    assign sel_val = bins_reg[bin_sel];

    always_comb
    begin
        for (int k = 0; k < BINS; k++)
            bins_next[k] = bins_reg[k];
        if (ctrl.clear)
        begin
            for (int k = 0; k < BINS; k++)
                bins_next[k] = '0;
        end
        else if (ctrl.shift)
        begin
            for (int k = 0; k < BINS - 1; k++)
                bins_next[k] = bins_reg[k+1];
            bins_next[BINS-1] = '0;
        end
        else if (ctrl.inc && (sel_val != {TOTAL_W{1'b1}}))
        begin
            bins_next[bin_sel] = sel_val + TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BINS; k++)
            bins_reg[k] <= bins_next[k];
    end

    assign head = bins_reg[0];

endmodule

// ----- sv/hash_bucket_occupancy_histogram.sv -----
// ----------------------------------------------------------------------------
// hash_bucket_occupancy_histogram
// Hashes 256-bit keys into buckets (key mod bucket count), keeps a saturating
// tally per bucket, and on a report emits how many buckets hold each occupancy.
// ----------------------------------------------------------------------------
//
//  channel | signals                                     | item
//  --------+---------------------------------------------+---------------------
//  cfg     | cfg_valid, cfg_ready, bucket_count          | bucket count write
//  req     | req_valid, req_ready, command, key_word_0..3| add key / report
//  bin     | bin_valid, bin_ready, occupancy,            | one histogram bin
//          | bucket_total, last_bin                      |
//
//  Add key: accept, reduction in the compare/subtract unit
//    (8 key bits a cycle), remainder handover, tally read, tally write.
//  Report: a sweep of the tally memory (read and zero one bucket a cycle,
//    counting the buckets in use), then BIN_COUNT items, one a cycle without stalls.
//  After reset a clearing pass over all MAX_BUCKETS entries zeroes the tallies;
//    req_ready stays low meanwhile, configuration writes are taken as ever.
//  A stalled bin item holds the report walk; the last bin may still wait in
//    the output register while the next request is accepted.
//
module hash_bucket_occupancy_histogram
    import hbo_pkg::*;
#(
    parameter int MAX_BUCKETS = 65536,
    parameter int BIN_COUNT   = 20
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MOD_W-1:0]   bucket_count,

    input  logic               req_valid,
    output logic               req_ready,
    input  logic               command,
    input  logic [WORD_W-1:0]  key_word_0,
    input  logic [WORD_W-1:0]  key_word_1,
    input  logic [WORD_W-1:0]  key_word_2,
    input  logic [WORD_W-1:0]  key_word_3,

    output logic               bin_valid,
    input  logic               bin_ready,
    output logic [OCC_W-1:0]   occupancy,
    output logic [TOTAL_W-1:0] bucket_total,
    output logic               last_bin
);

    localparam int IDX_W     = $clog2(MAX_BUCKETS);
    localparam int TW        = $clog2(BIN_COUNT);
    localparam int CMP_W     = (IDX_W > MOD_W) ? IDX_W : MOD_W;
    localparam int N_LIMIT   = (MAX_BUCKETS < (2**MOD_W - 1)) ? MAX_BUCKETS : (2**MOD_W - 1);
    localparam logic [MOD_W-1:0] N_MAX    = MOD_W'(N_LIMIT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BUCKETS - 1);
    localparam logic [TW-1:0]    TALLY_MAX = TW'(BIN_COUNT - 1);

    // configuration
    logic [MOD_W-1:0] bcount_reg;
    logic [MOD_W-1:0] n_eff;

    // sequencer
    state_t            state_reg,  state_next;
    logic [IDX_W-1:0]  sweep_reg,  sweep_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [MOD_W-1:0]  n_reg,      n_next;
    logic              pend_reg,   pend_next;
    logic [TW-1:0]     emit_reg,   emit_next;

    // output register
    logic               ovld_reg,  ovld_next;
    logic [OCC_W-1:0]   occ_reg,   occ_next;
    logic [TOTAL_W-1:0] tot_reg,   tot_next;
    logic               last_reg,  last_next;

    // datapath links
    logic              req_acc;
    logic              mod_start;
    logic              mod_done;
    logic [MOD_W-1:0]  mod_rem;
    logic [IDX_W-1:0]  mem_addr;
    logic              mem_rd;
    logic              mem_we;
    logic [TW-1:0]     mem_wdata;
    logic [TW-1:0]     mem_rdata;
    bin_ctrl_t         bin_ctrl;
    logic [TOTAL_W-1:0] bin_head;
    logic              out_free;

    // Buckets in use: zero counts as one, clamp to the table size
    always_comb
    begin
        if (bcount_reg == '0)
            n_eff = MOD_W'(1);
        else if (bcount_reg > N_MAX)
            n_eff = N_MAX;
        else
            n_eff = bcount_reg;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= MOD_W'(65536);
        else if (cfg_valid)
            bcount_reg <= bucket_count;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign mod_start = req_acc && (command == CMD_ADD);
    assign out_free  = !ovld_reg || bin_ready;

    hbo_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .key       ({key_word_0, key_word_1, key_word_2, key_word_3}),
        .modulus   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Memory port sharing: key update uses idx_reg, sweeps use sweep_reg
    always_comb
    begin
        mem_addr  = sweep_reg;
        mem_rd    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
            end
            S_SWEEP:
            begin
                mem_rd = 1'b1;
                mem_we = 1'b1;
            end
            S_RD:
            begin
                mem_addr = idx_reg;
                mem_rd   = 1'b1;
            end
            S_WR:
            begin
                mem_addr  = idx_reg;
                mem_we    = 1'b1;
                mem_wdata = (mem_rdata == TALLY_MAX) ? mem_rdata : mem_rdata + TW'(1);
            end
            default:
            begin
                mem_addr = sweep_reg;
            end
        endcase
    end

    hbo_tally_mem #(
        .DEPTH (MAX_BUCKETS),
        .AW    (IDX_W),
        .DW    (TW)
    ) u_tally (
        .clk   (clk),
        .addr  (mem_addr),
        .rd_en (mem_rd),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    hbo_bin_bank #(
        .BINS (BIN_COUNT),
        .BW   (TW)
    ) u_bins (
        .clk     (clk),
        .ctrl    (bin_ctrl),
        .bin_sel (mem_rdata),
        .head    (bin_head)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        pend_next  = 1'b0;
        emit_next  = emit_reg;
        ovld_next  = ovld_reg;
        occ_next   = occ_reg;
        tot_next   = tot_reg;
        last_next  = last_reg;
        bin_ctrl   = '{clear: 1'b0, inc: pend_reg, shift: 1'b0};

        if (ovld_reg && bin_ready)
            ovld_next = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == IDX_LAST)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_acc)
                begin
                    n_next = n_eff;
                    if (command == CMD_REPORT)
                    begin
                        bin_ctrl.clear = 1'b1;
                        sweep_next     = '0;
                        state_next     = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    idx_next   = IDX_W'(mod_rem);
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                // only buckets in use are counted; all are zeroed
                pend_next  = CMP_W'(sweep_reg) < CMP_W'(n_reg);
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == IDX_LAST)
                begin
                    sweep_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                emit_next  = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    bin_ctrl.shift = 1'b1;
                    ovld_next      = 1'b1;
                    occ_next       = OCC_W'(emit_reg);
                    tot_next       = bin_head;
                    last_next      = (emit_reg == TALLY_MAX);
                    emit_next      = emit_reg + TW'(1);
                    if (emit_reg == TALLY_MAX)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
            emit_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
            emit_reg  <= emit_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        n_reg    <= n_next;
        occ_reg  <= occ_next;
        tot_reg  <= tot_next;
        last_reg <= last_next;
    end

    assign bin_valid    = ovld_reg;
    assign occupancy    = occ_reg;
    assign bucket_total = tot_reg;
    assign last_bin     = last_reg;

endmodule
